/* rtl/midi_redundant_message_filter_defines.svh */
// Assertion macros for the MIDI redundant message filter.
// Each check is sampled on the rising edge of i_clk and is ignored while i_rst_n is low.
`ifndef MIDI_REDUNDANT_MESSAGE_FILTER_DEFINES_SVH
`define MIDI_REDUNDANT_MESSAGE_FILTER_DEFINES_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define MRMF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define MRMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MRMF_ASSERT_SAME(lbl, ante, cons, msg)
`define MRMF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/mrmf_pkg.sv */
`default_nettype none

package mrmf_pkg;

    // Message geometry.
    localparam int CHANNELS = 16;
    localparam int KEYS     = 128;
    localparam int CH_W     = $clog2(CHANNELS);
    localparam int KEY_W    = $clog2(KEYS);
    localparam int MSG_W    = 24;

    // Tag memory: poly pressure in the lower half, control change in the upper half.
    localparam int MEM_DEPTH = 2 * CHANNELS * KEYS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int TAG_W     = 8;
    localparam logic [TAG_W-1:0] TAG_NONE = '0;
    localparam logic [TAG_W-1:0] TAG_MAX  = '1;

    // Output queue.
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Upper status nibble.
    localparam logic [3:0] KIND_POLY_PRESS = 4'hA;
    localparam logic [3:0] KIND_CTRL       = 4'hB;
    localparam logic [3:0] KIND_CHAN_PRESS = 4'hD;
    localparam logic [3:0] KIND_PITCH      = 4'hE;
    localparam logic [3:0] KIND_SYSTEM     = 4'hF;

    // Verdict codes.
    localparam logic [2:0] VERDICT_KEPT       = 3'd0;
    localparam logic [2:0] VERDICT_SUPERSEDED = 3'd1;
    localparam logic [2:0] VERDICT_BAD_STATUS = 3'd2;
    localparam logic [2:0] VERDICT_BAD_DATA   = 3'd3;
    localparam logic [2:0] VERDICT_SYSTEM     = 3'd4;

    typedef struct packed {
        logic             keep;
        logic [MSG_W-1:0] msg;
        logic [2:0]       verdict;
    } t_result;

endpackage

`default_nettype wire

/* rtl/midi_redundant_message_filter.sv */
`default_nettype none

// Channel    Dir  Handshake                          Payload
// s_axis     in   i_s_axis_tvalid / o_s_axis_tready  tdata message, tuser first_in_batch
// m_axis     out  o_m_axis_tvalid / i_m_axis_tready  tdata message_out, tuser keep, verdict
//
// One item per cycle is taken while s_axis ready is high; results pass the judge stage, then the queue.
// The limit is the tag RAM: one read and at most one write-back per item, with one-deep forwarding.
// After reset, a clearing pass writes all 4096 tag entries, and no item is accepted meanwhile.
// A batch mark with the 8-bit generation exhausted, once every 255 batches, reruns that pass.
// A three-entry output queue absorbs downstream stalls; s_axis ready drops while the queue
// and the judge stage together hold three results, during a clearing pass, and while a wrap is pending.
`include "midi_redundant_message_filter_defines.svh"

module midi_redundant_message_filter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,   // [23:0] message
    input  wire logic        i_s_axis_tuser,   // [0] first_in_batch
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [23:0] o_m_axis_tdata,   // [23:0] message_out
    output logic      [3:0]  o_m_axis_tuser    // [0] keep, [3:1] verdict
);

    localparam logic ST_RUN   = 1'b0;
    localparam logic ST_SWEEP = 1'b1;

    // Control state.
    logic                               r_state;
    logic [mrmf_pkg::ADDR_W-1:0]        r_sweep_addr;
    logic [mrmf_pkg::TAG_W-1:0]         r_epoch;
    logic                               r_fresh;
    logic                               r_s1_valid;
    logic [mrmf_pkg::CHANNELS-1:0]      r_cp_seen;
    logic [mrmf_pkg::CHANNELS-1:0]      r_pb_seen;
    logic [mrmf_pkg::FIFO_PW-1:0]       r_wptr;
    logic [mrmf_pkg::FIFO_PW-1:0]       r_rptr;
    logic [mrmf_pkg::FIFO_CW-1:0]       r_cnt;

    // Payload of the item in the judge stage.
    logic [mrmf_pkg::MSG_W-1:0]         r_s1_msg;
    logic                               r_s1_mark;
    logic [mrmf_pkg::TAG_W-1:0]         r_s1_epoch;
    logic [mrmf_pkg::ADDR_W-1:0]        r_s1_addr;
    logic                               r_s1_fwd;
    logic [mrmf_pkg::TAG_W-1:0]         r_fwd_tag;
    mrmf_pkg::t_result                  r_fifo [mrmf_pkg::FIFO_DEPTH];

    logic                               w_accept;
    logic                               w_space;
    logic                               w_wrap;
    logic                               w_pop;
    logic [mrmf_pkg::ADDR_W-1:0]        w_rd_addr;
    logic [mrmf_pkg::TAG_W-1:0]         w_rd_tag;
    logic [mrmf_pkg::TAG_W-1:0]         n_epoch;
    logic                               w_s1_write;
    logic                               w_we;
    logic [mrmf_pkg::ADDR_W-1:0]        w_waddr;
    logic [mrmf_pkg::TAG_W-1:0]         w_wdata;
    mrmf_pkg::t_result                  w_result;
    logic [mrmf_pkg::CHANNELS-1:0]      n_cp_seen;
    logic [mrmf_pkg::CHANNELS-1:0]      n_pb_seen;

    // Input side: no clearing pass, room for the item in flight plus this one, and no generation wrap pending.
    assign w_space = ({1'b0, r_cnt} + (mrmf_pkg::FIFO_CW + 1)'(r_s1_valid))
                     < (mrmf_pkg::FIFO_CW + 1)'(mrmf_pkg::FIFO_DEPTH);
    assign w_wrap  = (r_epoch == mrmf_pkg::TAG_MAX) && !r_fresh && i_s_axis_tuser;
    assign o_s_axis_tready = (r_state == ST_RUN) && w_space && !w_wrap;
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    // A batch mark opens a new generation unless the tags were just swept.
    assign n_epoch = (i_s_axis_tuser && !r_fresh)
                     ? r_epoch + mrmf_pkg::TAG_W'(1) : r_epoch;

    // Tag address: control change in the upper half, then channel, then key or controller.
    assign w_rd_addr = {(i_s_axis_tdata[7:4] == mrmf_pkg::KIND_CTRL),
                        i_s_axis_tdata[mrmf_pkg::CH_W-1:0],
                        i_s_axis_tdata[8 +: mrmf_pkg::KEY_W]};

    // Write port: the clearing pass or the judge stage's write-back.
    assign w_we    = (r_state == ST_SWEEP) || w_s1_write;
    assign w_waddr = (r_state == ST_SWEEP) ? r_sweep_addr : r_s1_addr;
    assign w_wdata = (r_state == ST_SWEEP) ? mrmf_pkg::TAG_NONE : r_s1_epoch;

    mrmf_ram #(
        .WIDTH (mrmf_pkg::TAG_W),
        .DEPTH (mrmf_pkg::MEM_DEPTH)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_tag)
    );

    // Judge stage: decode, test the flag and build the result.
    always_comb begin
        logic [3:0]                 kind;
        logic [mrmf_pkg::CH_W-1:0]  chan;
        logic [7:0]                 d1;
        logic [7:0]                 d2;
        logic [mrmf_pkg::TAG_W-1:0] tag;
        logic                       big_seen;
        logic [2:0]                 verdict;
        kind     = r_s1_msg[7:4];
        chan     = r_s1_msg[mrmf_pkg::CH_W-1:0];
        d1       = r_s1_msg[15:8];
        d2       = r_s1_msg[23:16];
        tag      = r_s1_fwd ? r_fwd_tag : w_rd_tag;
        big_seen = (tag == r_s1_epoch);
        n_cp_seen = r_s1_mark ? '0 : r_cp_seen;
        n_pb_seen = r_s1_mark ? '0 : r_pb_seen;
        w_s1_write = 1'b0;
        verdict = mrmf_pkg::VERDICT_KEPT;
        if (!r_s1_msg[7]) begin
            verdict = mrmf_pkg::VERDICT_BAD_STATUS;
        end else if (d1[7] || d2[7]) begin
            verdict = mrmf_pkg::VERDICT_BAD_DATA;
        end else begin
            case (kind) inside
                mrmf_pkg::KIND_POLY_PRESS, mrmf_pkg::KIND_CTRL: begin
                    if (big_seen) begin
                        verdict = mrmf_pkg::VERDICT_SUPERSEDED;
                    end else begin
                        w_s1_write = 1'b1;
                    end
                end
                mrmf_pkg::KIND_CHAN_PRESS: begin
                    if (n_cp_seen[chan]) begin
                        verdict = mrmf_pkg::VERDICT_SUPERSEDED;
                    end else begin
                        n_cp_seen[chan] = 1'b1;
                    end
                end
                mrmf_pkg::KIND_PITCH: begin
                    if (n_pb_seen[chan]) begin
                        verdict = mrmf_pkg::VERDICT_SUPERSEDED;
                    end else begin
                        n_pb_seen[chan] = 1'b1;
                    end
                end
                mrmf_pkg::KIND_SYSTEM: begin
                    verdict = mrmf_pkg::VERDICT_SYSTEM;
                end
                default: begin
                    verdict = mrmf_pkg::VERDICT_KEPT;
                end
            endcase
        end
        w_s1_write       = w_s1_write && r_s1_valid;
        w_result.keep    = (verdict == mrmf_pkg::VERDICT_KEPT);
        w_result.msg     = w_result.keep ? r_s1_msg : '0;
        w_result.verdict = verdict;
    end

    // Sequencer: clearing pass and generation bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep_addr <= '0;
            r_epoch      <= mrmf_pkg::TAG_NONE;
            r_fresh      <= 1'b0;
        end else begin
            unique case (r_state)
                ST_SWEEP: begin
                    r_sweep_addr <= r_sweep_addr + mrmf_pkg::ADDR_W'(1);
                    if (r_sweep_addr == mrmf_pkg::ADDR_W'(mrmf_pkg::MEM_DEPTH - 1)) begin
                        r_state <= ST_RUN;
                        r_epoch <= mrmf_pkg::TAG_W'(1);
                        r_fresh <= 1'b1;
                    end
                end
                ST_RUN: begin
                    if (w_accept) begin
                        r_epoch <= n_epoch;
                        r_fresh <= 1'b0;
                    end else if (i_s_axis_tvalid && w_wrap && !r_s1_valid) begin
                        r_state      <= ST_SWEEP;
                        r_sweep_addr <= '0;
                    end
                end
                default: begin
                    r_state <= ST_SWEEP;
                end
            endcase
        end
    end

    // Judge stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_cp_seen  <= '0;
            r_pb_seen  <= '0;
        end else begin
            r_s1_valid <= w_accept;
            if (r_s1_valid) begin
                r_cp_seen <= n_cp_seen;
                r_pb_seen <= n_pb_seen;
            end
        end
    end

    // A read issued while the judge stage writes the same entry sees the old tag: forward it.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_msg   <= i_s_axis_tdata;
            r_s1_mark  <= i_s_axis_tuser;
            r_s1_epoch <= n_epoch;
            r_s1_addr  <= w_rd_addr;
            r_s1_fwd   <= w_s1_write && (r_s1_addr == w_rd_addr);
            r_fwd_tag  <= r_s1_epoch;
        end
    end

    // Output queue.
    assign w_pop = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (r_s1_valid) begin
                r_wptr <= (r_wptr == mrmf_pkg::FIFO_PW'(mrmf_pkg::FIFO_DEPTH - 1))
                          ? '0 : r_wptr + mrmf_pkg::FIFO_PW'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == mrmf_pkg::FIFO_PW'(mrmf_pkg::FIFO_DEPTH - 1))
                          ? '0 : r_rptr + mrmf_pkg::FIFO_PW'(1);
            end
            if (r_s1_valid && !w_pop) begin
                r_cnt <= r_cnt + mrmf_pkg::FIFO_CW'(1);
            end else if (!r_s1_valid && w_pop) begin
                r_cnt <= r_cnt - mrmf_pkg::FIFO_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_fifo[r_wptr] <= w_result;
        end
    end

    assign o_m_axis_tvalid = (r_cnt != '0);
    assign o_m_axis_tdata  = r_fifo[r_rptr].msg;
    assign o_m_axis_tuser  = {r_fifo[r_rptr].verdict, r_fifo[r_rptr].keep};

    // No item may enter while the tag memory is being cleared.
    `MRMF_ASSERT_SAME(a_no_accept_in_sweep, r_state == ST_SWEEP, !o_s_axis_tready, "accept during sweep")
    // The judge stage never pushes into a full output queue.
    `MRMF_ASSERT_SAME(a_queue_room, r_s1_valid, r_cnt != mrmf_pkg::FIFO_CW'(mrmf_pkg::FIFO_DEPTH), "queue overflow")
    // Swept entries hold the empty tag, so a running generation must never equal it.
    `MRMF_ASSERT_SAME(a_epoch_live, r_state == ST_RUN, r_epoch != mrmf_pkg::TAG_NONE, "empty tag in use")
    // The sweep only starts once the judge stage has written back.
    `MRMF_ASSERT_NEXT(a_sweep_start, r_state == ST_RUN && r_s1_valid, r_state == ST_RUN, "sweep over pending write")

endmodule

`default_nettype wire

/* rtl/mrmf_ram.sv */
`default_nettype none

// Simple dual-port RAM: one write port and one read port with a registered read.
// A read at the address being written in the same cycle returns the old data.
module mrmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
